// ===== hdl/case_insensitive_multi_pattern_match_assert.svh =====
// Assertion macros for the case-insensitive multi-pattern matcher.
// Used by the port checker; needs nothing else.
`ifndef CASE_INSENSITIVE_MULTI_PATTERN_MATCH_ASSERT_SVH
`define CASE_INSENSITIVE_MULTI_PATTERN_MATCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CIMPM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cimpm assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CIMPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cimpm assertion failed");

// Next-cycle implication that also holds across reset.
`define CIMPM_ASSERT_NEXT_RAW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cimpm assertion failed");

`endif

// ===== hdl/cimpm_pkg.sv =====
// Shared constants, types and the case-folding function of the matcher.
// Used by every module of the block; depends on nothing.
package cimpm_pkg;

    localparam int SLOTS      = 32;
    localparam int MAX_LEN    = 16;

    localparam int SLOT_W     = 5;
    localparam int POS_W      = 4;
    localparam int PCHAR_W    = 8;
    localparam int PLEN_W     = 5;
    localparam int CHAR_W     = 16;

    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int CHAR_IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam logic [CHAR_W-1:0] UPPER_A     = 16'h0041;
    localparam logic [CHAR_W-1:0] UPPER_Z     = 16'h005A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'd32;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_SCAN  = 1'b1
    } t_action;

    // One word as it moves down the cell chain.
    typedef struct packed {
        logic                             valid;
        t_action                          action;
        logic [SLOT_W-1:0]                slot;
        logic [POS_W-1:0]                 pos;
        logic [PCHAR_W-1:0]               pchar;
        logic [LEN_W-1:0]                 plen;
        logic [MAX_LEN-1:0][CHAR_W-1:0]   win;
        logic [LEN_W-1:0]                 seen;
        logic                             last;
        logic                             hit;
    } t_item;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] ch);
        fold_char = ((ch >= UPPER_A) && (ch <= UPPER_Z)) ? ch + CASE_OFFSET : ch;
    endfunction

endpackage

// ===== hdl/cimpm_head.sv =====
// Front of the chain: unpacks input words, keeps the folded window of recent
// name characters and its fill count. Depends on cimpm_pkg.
module cimpm_head (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [cimpm_pkg::S_TDATA_W-1:0] i_data,
    input  logic                           i_user,
    input  logic                           i_last,
    output cimpm_pkg::t_item               o_item
);

    logic [cimpm_pkg::MAX_LEN-1:0][cimpm_pkg::CHAR_W-1:0] r_win, n_win, win_next;
    logic [cimpm_pkg::LEN_W-1:0]   r_seen, n_seen, seen_next;
    cimpm_pkg::t_item              r_item, n_item;
    logic                          accept;
    logic [cimpm_pkg::CHAR_W-1:0]  name_fold;
    logic [cimpm_pkg::PCHAR_W-1:0] pat_fold;
    logic [cimpm_pkg::PLEN_W-1:0]  plen_in;

    assign accept = i_valid && i_en;

    always_comb begin
        name_fold = cimpm_pkg::fold_char(i_data[37:22]);
        pat_fold  = cimpm_pkg::PCHAR_W'(cimpm_pkg::fold_char({8'h00, i_data[16:9]}));
        plen_in   = i_data[21:17];

        win_next[0] = name_fold;
        for (int k = 1; k < cimpm_pkg::MAX_LEN; k++) begin
            win_next[k] = r_win[k-1];
        end
        seen_next = (r_seen == cimpm_pkg::LEN_W'(cimpm_pkg::MAX_LEN)) ?
                    r_seen : r_seen + cimpm_pkg::LEN_W'(1);

        n_item.valid  = accept;
        n_item.action = cimpm_pkg::t_action'(i_user);
        n_item.slot   = i_data[4:0];
        n_item.pos    = i_data[8:5];
        n_item.pchar  = pat_fold;
        n_item.plen   = (32'(plen_in) > cimpm_pkg::MAX_LEN) ?
                        cimpm_pkg::LEN_W'(cimpm_pkg::MAX_LEN) :
                        cimpm_pkg::LEN_W'(plen_in);
        n_item.win    = win_next;
        n_item.seen   = seen_next;
        n_item.last   = i_last;
        n_item.hit    = 1'b0;

        n_win  = r_win;
        n_seen = r_seen;
        if (accept && (n_item.action == cimpm_pkg::ACT_SCAN)) begin
            if (i_last) begin
                n_win  = '0;
                n_seen = '0;
            end else begin
                n_win  = win_next;
                n_seen = seen_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= '0;
            r_seen       <= '0;
            r_item.valid <= 1'b0;
        end else begin
            r_win  <= n_win;
            r_seen <= n_seen;
            if (i_en) begin
                r_item <= n_item;
            end
        end
    end

    assign o_item = r_item;

endmodule

// ===== hdl/cimpm_cell.sv =====
// One pattern slot: stores its folded characters and length, compares them
// with the window of the passing word and forwards the word. Depends on cimpm_pkg.
module cimpm_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [cimpm_pkg::IDX_W-1:0]  i_slot_index,
    input  cimpm_pkg::t_item             i_item,
    output cimpm_pkg::t_item             o_item
);

    logic [cimpm_pkg::PCHAR_W-1:0]    r_chars [cimpm_pkg::MAX_LEN];
    logic [cimpm_pkg::LEN_W-1:0]      r_len;
    cimpm_pkg::t_item                 r_item, n_item;
    logic                             wr, all_ok, slot_hit;
    logic [cimpm_pkg::CHAR_IDX_W-1:0] d;

    assign wr = i_en && i_item.valid && (i_item.action == cimpm_pkg::ACT_WRITE) &&
                (32'(i_item.slot) == 32'(i_slot_index)) &&
                (32'(i_item.pos) < cimpm_pkg::MAX_LEN);

    // Pattern character j lines up with window entry len-1-j.
    always_comb begin
        all_ok = 1'b1;
        d      = '0;
        for (int j = 0; j < cimpm_pkg::MAX_LEN; j++) begin
            d = cimpm_pkg::CHAR_IDX_W'(r_len - cimpm_pkg::LEN_W'(1) - cimpm_pkg::LEN_W'(j));
            if ((cimpm_pkg::LEN_W'(j) < r_len) &&
                ({{(cimpm_pkg::CHAR_W-cimpm_pkg::PCHAR_W){1'b0}}, r_chars[j]} !=
                 i_item.win[d])) begin
                all_ok = 1'b0;
            end
        end
        slot_hit = (r_len != '0) && (r_len <= i_item.seen) && all_ok;

        n_item     = i_item;
        n_item.hit = i_item.hit | slot_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (wr) begin
            r_len <= i_item.plen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            for (int k = 0; k < cimpm_pkg::MAX_LEN; k++) begin
                if (32'(i_item.pos) == k) begin
                    r_chars[k] <= i_item.pchar;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== hdl/cimpm_tail.sv =====
// End of the chain: keeps the sticky hit of the current name, holds the
// result word and derives the chain advance. Depends on cimpm_pkg.
module cimpm_tail (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cimpm_pkg::t_item i_item,
    input  logic             i_m_ready,
    output logic             o_en,
    output logic             o_m_valid,
    output logic             o_matched
);

    logic r_sticky, r_out_valid, r_matched;
    logic is_scan, need_out;

    assign is_scan  = i_item.valid && (i_item.action == cimpm_pkg::ACT_SCAN);
    assign need_out = is_scan && i_item.last;
    // The chain stalls only when a result arrives at a full, unread output.
    assign o_en     = !(need_out && r_out_valid && !i_m_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_en && is_scan) begin
                r_sticky <= i_item.last ? 1'b0 : (r_sticky | i_item.hit);
            end
            if (o_en && need_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && need_out) begin
            r_matched <= r_sticky | i_item.hit;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_matched = r_matched;

endmodule

// ===== hdl/case_insensitive_multi_pattern_match.sv =====
// Top level of the case-insensitive multi-pattern substring matcher.
// Instantiates cimpm_head, a row of cimpm_cell and cimpm_tail; uses cimpm_pkg.
//
// Every input word, pattern write or name character, enters a chain of a head
// stage and one register stage per pattern slot and moves one cell per cycle,
// so the block takes one word per cycle while not stalled; the result of a
// name is offered from the tail's output register once its last character has
// passed every cell. Writes travel in the same chain as name characters, so a
// write takes effect from the next scanned character. Input is held off only
// while a finished result reaches the end of the chain and the previous result
// is still waiting to be taken. Name characters are compared with only A-Z
// folded to lower case; characters above 255 never match a pattern character.
// Pattern lengths clear at reset; a slot's characters must be written before
// that slot is given a length that covers them.
module case_insensitive_multi_pattern_match (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [4:0] pattern_slot, [8:5] char_position, [16:9] pattern_char,
    // [21:17] pattern_length, [37:22] name_char, [39:38] zero
    input  logic [cimpm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] action: 0 write pattern character, 1 scan name character
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] matched, [7:1] zero
    output logic [cimpm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    cimpm_pkg::t_item chain [cimpm_pkg::SLOTS+1];
    logic             en;
    logic             matched;

    assign s_axis_tready = en;

    cimpm_head u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .i_last  (s_axis_tlast),
        .o_item  (chain[0])
    );

    for (genvar k = 0; k < cimpm_pkg::SLOTS; k++) begin : g_cell
        cimpm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (en),
            .i_slot_index (cimpm_pkg::IDX_W'(k)),
            .i_item       (chain[k]),
            .o_item       (chain[k+1])
        );
    end

    cimpm_tail u_tail (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (chain[cimpm_pkg::SLOTS]),
        .i_m_ready (m_axis_tready),
        .o_en      (en),
        .o_m_valid (m_axis_tvalid),
        .o_matched (matched)
    );

    assign m_axis_tdata = {{(cimpm_pkg::M_TDATA_W-1){1'b0}}, matched};

endmodule

// ===== hdl/cimpm_checker.sv =====
// Port checker for the matcher, bound to the top level.
// Depends on cimpm_pkg and the assertion macro header.
`include "case_insensitive_multi_pattern_match_assert.svh"

module cimpm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cimpm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // No result word survives a reset.
    `CIMPM_ASSERT_NEXT_RAW(a_reset_clears_out, i_clk, !i_rst_n, !m_axis_tvalid)

    // A result that is not taken stays put.
    `CIMPM_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // With an empty output register the input side never stalls.
    `CIMPM_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

    // A draining output never holds off the input side.
    `CIMPM_ASSERT_NOW(a_ready_when_drain, i_clk, i_rst_n, m_axis_tready, s_axis_tready)

endmodule

bind case_insensitive_multi_pattern_match cimpm_checker u_cimpm_checker (.*);
